// ----- hdl/lzd_pkg.sv -----
// Shared types, constants and the window preset function for the LZSS byte decompressor.
// No dependencies; every other file of the block imports this package.
package lzd_pkg;

    localparam int HISTORY_SIZE_DEF = 4096;
    localparam int WIN_W            = 12;
    localparam int CMD_DEPTH_DEF    = 4;
    localparam int OUT_DEPTH_DEF    = 4;

    localparam logic [WIN_W-1:0] WRITE_START = 12'hFEE;

    // parser phases
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_OFF2 = 2'd2;

    // command kinds between parser and executor
    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_LIT  = 2'd1;
    localparam logic [1:0] CMD_COPY = 2'd2;

    localparam logic [4:0] MIN_MATCH  = 5'd3;
    localparam logic [3:0] RUN_REPEAT = 4'd13;

    // preset layout boundaries
    localparam logic [WIN_W-1:0] FILL_ASC_BASE  = 12'd3328;
    localparam logic [WIN_W-1:0] FILL_DESC_BASE = 12'd3584;
    localparam logic [WIN_W-1:0] FILL_ZERO_BASE = 12'd3840;
    localparam logic [WIN_W-1:0] FILL_SP_BASE   = 12'd3968;
    localparam logic [WIN_W-1:0] FILL_TAIL_BASE = 12'd4078;
    localparam logic [7:0]       FILL_SPACE     = 8'h20;

    typedef struct packed {
        logic [1:0]       kind;
        logic [WIN_W-1:0] addr;   // match offset, or literal in the low byte
        logic [4:0]       len;
        logic             done;   // last byte of this command ends the stream
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_res;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    // Preset window content; run_val is the value of the 13-fold run region.
    function automatic logic [7:0] lzd_fill(input logic [WIN_W-1:0] addr,
                                            input logic [7:0] run_val);
        logic [7:0] v;
        if (addr < FILL_ASC_BASE) begin
            v = run_val;
        end else if (addr < FILL_DESC_BASE) begin
            v = addr[7:0];
        end else if (addr < FILL_ZERO_BASE) begin
            v = ~addr[7:0];
        end else if (addr < FILL_SP_BASE) begin
            v = 8'h00;
        end else if (addr < FILL_TAIL_BASE) begin
            v = FILL_SPACE;
        end else begin
            v = 8'h00;
        end
        return v;
    endfunction

endpackage

// ----- hdl/lzd_queue.sv -----
// Small first-in first-out queue of fixed-width words, registers only.
// Depends on lzd_pkg for default sizes.
module lzd_queue #(
    parameter int W     = lzd_pkg::CMD_W,
    parameter int DEPTH = lzd_pkg::CMD_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import lzd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          full;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign full    = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ----- hdl/lzd_front.sv -----
// Parser: takes compressed bytes, tracks flag bits, phase and output count,
// and turns them into literal, copy and window-init commands. Uses lzd_pkg.
module lzd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  logic [31:0]         i_out_length,
    input  logic                i_cmd_full,
    output logic                o_cmd_push,
    output lzd_pkg::t_cmd       o_cmd
);
    import lzd_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [8:0]  r_flag, n_flag;
    logic [7:0]  r_offlo, n_offlo;
    logic [31:0] r_count, n_count;

    logic [1:0]  e_phase;
    logic [8:0]  e_flag, sh_flag;
    logic [31:0] e_count, room;
    logic        accept, active;
    logic [4:0]  mlen, mlen_eff;
    logic [1:0]  after_phase;

    assign o_ready = !i_cmd_full;
    assign accept  = i_valid && o_ready;

    assign e_phase = i_start ? PH_FLAG : r_phase;
    assign e_flag  = i_start ? 9'd0 : r_flag;
    assign e_count = i_start ? 32'd0 : r_count;
    assign room    = i_out_length - e_count;
    assign active  = (e_count < i_out_length);
    assign sh_flag = e_flag >> 1;
    assign after_phase = (sh_flag <= 9'd1) ? PH_FLAG : PH_BODY;

    assign mlen     = {1'b0, i_byte[3:0]} + MIN_MATCH;
    assign mlen_eff = ({27'd0, mlen} > room) ? room[4:0] : mlen;

    always_comb begin
        n_phase    = r_phase;
        n_flag     = r_flag;
        n_offlo    = r_offlo;
        n_count    = r_count;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (accept) begin
            n_phase = e_phase;
            n_flag  = e_flag;
            n_count = e_count;
            if (i_start) begin
                o_cmd_push = 1'b1;
                o_cmd.kind = CMD_INIT;
            end
            if (active) begin
                case (e_phase)
                    PH_FLAG: begin
                        n_flag  = {1'b1, i_byte};
                        n_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        if (e_flag[0]) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_LIT;
                            o_cmd.addr = {{(WIN_W-8){1'b0}}, i_byte};
                            o_cmd.len  = 5'd1;
                            o_cmd.done = (room == 32'd1);
                            n_count    = e_count + 32'd1;
                            n_flag     = sh_flag;
                            n_phase    = after_phase;
                        end else begin
                            n_offlo = i_byte;
                            n_phase = PH_OFF2;
                        end
                    end
                    PH_OFF2: begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_COPY;
                        o_cmd.addr = {i_byte[7:4], r_offlo};
                        o_cmd.len  = mlen_eff;
                        o_cmd.done = ({27'd0, mlen} >= room);
                        n_count    = e_count + {27'd0, mlen_eff};
                        n_flag     = sh_flag;
                        n_phase    = after_phase;
                    end
                    default: begin
                        n_phase = PH_FLAG;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_flag  <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_flag  <= n_flag;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offlo <= n_offlo;
    end

endmodule

// ----- hdl/lzd_back.sv -----
// Executor: owns the history window, runs the preset fill, and plays literal and
// copy commands into the result queue, one byte per cycle unless full. Uses lzd_pkg.
module lzd_back #(
    parameter int HISTORY_SIZE = lzd_pkg::HISTORY_SIZE_DEF,
    parameter int OUT_DEPTH    = lzd_pkg::OUT_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_empty,
    input  lzd_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                             o_res_push,
    output lzd_pkg::t_res                    o_res
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_SIZE);
    localparam int CW = $clog2(OUT_DEPTH+1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COPY = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [7:0]    r_hist [HISTORY_SIZE];
    logic [7:0]    r_q;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_src, n_src;
    logic [4:0]    r_left, n_left;
    logic          r_done, n_done;
    logic [AW-1:0] r_faddr, n_faddr;
    logic [7:0]    r_fval, n_fval;
    logic [3:0]    r_fk, n_fk;

    // issue stage (one byte in flight toward the write/output stage)
    logic          r_pend, n_pend;
    logic          r_plit, n_plit;
    logic [7:0]    r_pbyte, n_pbyte;
    logic          r_plast, n_plast;
    logic          r_pdone, n_pdone;
    logic          r_byp;
    logic [7:0]    r_bdata;

    logic          space, issue_rd, mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd, d2;

    assign space = ({1'b0, i_out_count} + (CW+1)'(r_pend)) < (CW+1)'(OUT_DEPTH);
    assign d2    = r_plit ? r_pbyte : (r_byp ? r_bdata : r_q);

    assign o_res_push = r_pend;
    assign o_res      = '{data: d2, last: r_plast, done: r_pdone};

    always_comb begin
        n_state   = r_state;
        n_wp      = r_pend ? r_wp + 1'b1 : r_wp;
        n_src     = r_src;
        n_left    = r_left;
        n_done    = r_done;
        n_faddr   = r_faddr;
        n_fval    = r_fval;
        n_fk      = r_fk;
        n_pend    = 1'b0;
        n_plit    = 1'b0;
        n_pbyte   = i_cmd.addr[7:0];
        n_plast   = 1'b0;
        n_pdone   = 1'b0;
        o_cmd_pop = 1'b0;
        issue_rd  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        CMD_INIT: begin
                            o_cmd_pop = 1'b1;
                            n_state   = ST_FILL;
                            n_faddr   = '0;
                            n_fval    = '0;
                            n_fk      = '0;
                        end
                        CMD_LIT: begin
                            if (space) begin
                                o_cmd_pop = 1'b1;
                                n_pend    = 1'b1;
                                n_plit    = 1'b1;
                                n_plast   = 1'b1;
                                n_pdone   = i_cmd.done;
                            end
                        end
                        CMD_COPY: begin
                            o_cmd_pop = 1'b1;
                            n_src     = AW'(i_cmd.addr);
                            n_left    = i_cmd.len;
                            n_done    = i_cmd.done;
                            n_state   = ST_COPY;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                if (space) begin
                    issue_rd = 1'b1;
                    n_pend   = 1'b1;
                    n_plast  = (r_left == 5'd1);
                    n_pdone  = r_done && (r_left == 5'd1);
                    n_src    = r_src + 1'b1;
                    n_left   = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                n_faddr = r_faddr + 1'b1;
                if (r_fk == RUN_REPEAT - 4'd1) begin
                    n_fk   = '0;
                    n_fval = r_fval + 8'd1;
                end else begin
                    n_fk = r_fk + 4'd1;
                end
                if (r_faddr == AW'(HISTORY_SIZE-1)) begin
                    n_state = ST_IDLE;
                    n_wp    = AW'(WRITE_START);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // one write port: the output stage, or the preset sweep when nothing is in flight
    assign mem_we = r_pend || (r_state == ST_FILL);
    assign mem_wa = r_pend ? r_wp : r_faddr;
    assign mem_wd = r_pend ? d2 : lzd_fill(WIN_W'(r_faddr), r_fval);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wa] <= mem_wd;
        end
        r_q <= r_hist[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_wp    <= AW'(WRITE_START);
            r_faddr <= '0;
            r_fval  <= '0;
            r_fk    <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_faddr <= n_faddr;
            r_fval  <= n_fval;
            r_fk    <= n_fk;
            r_pend  <= n_pend;
            r_left  <= n_left;
        end
    end

    // a read that hits the address written in the same cycle takes the new byte
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_done  <= n_done;
        r_plit  <= n_plit;
        r_pbyte <= n_pbyte;
        r_plast <= n_plast;
        r_pdone <= n_pdone;
        r_byp   <= issue_rd && r_pend && (r_src == r_wp);
        r_bdata <= d2;
    end

endmodule

// ----- hdl/lzss_byte_decompressor.sv -----
// LZSS byte decompressor, top level: config register, parser, command queue,
// executor with the 4 KiB window, and result queue. Uses lzd_pkg and all lzd_* modules.
//
// Compressed bytes enter on the slave stream, one per transfer; decompressed
// bytes leave on the master stream. Flag bytes and first match bytes yield
// no result; a literal yields one byte; a match yields 3 to 18 bytes, cut
// short at the configured length, with tlast on the final byte of each input
// and tuser (stream_done) on the byte that reaches the configured length.
// Once the length is reached every further input is dropped until
// tuser (stream_start) on an input or a larger length resumes decoding.
// Timing: the parser takes one input per cycle while the 4-entry command queue
// has room; the executor pops a match command before playing its bytes, the
// window's single read and write port giving one output byte per cycle while
// the result queue has room. After reset, and for every stream_start input, the
// executor sweeps the preset pattern into all 4096 window entries, one entry a
// cycle; inputs keep queueing meanwhile up to the queue depth. The user must write
// the length register through the cfg channel only while idle; it is not enforced.
module lzss_byte_decompressor #(
    parameter int HISTORY_SIZE = lzd_pkg::HISTORY_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: out_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // compressed input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] stream_start
    // decompressed output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,   // last_of_run
    output logic        o_m_tuser    // [0] stream_done
);
    import lzd_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH_DEF+1);
    localparam int QCW = $clog2(CMD_DEPTH_DEF+1);

    logic [31:0]    r_out_length;

    logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd           cmd_in, cmd_out;
    logic [QCW-1:0] cmd_count;

    logic           res_push, res_empty;
    t_res           res_in, res_out;
    logic [OCW-1:0] res_count;

    assign o_cfg_ready = 1'b1;
    assign cmd_full    = (cmd_count == QCW'(CMD_DEPTH_DEF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= '0;
        end else if (i_cfg_valid) begin
            r_out_length <= i_cfg_data;
        end
    end

    lzd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_start      (i_s_tuser),
        .i_out_length (r_out_length),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    lzd_queue #(
        .W     (CMD_W),
        .DEPTH (CMD_DEPTH_DEF)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    lzd_back #(
        .HISTORY_SIZE (HISTORY_SIZE),
        .OUT_DEPTH    (OUT_DEPTH_DEF)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue decouples the output handshake from the window pipeline;
    // the executor only issues a byte when a slot is guaranteed
    lzd_queue #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH_DEF)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (i_m_tready),
        .o_data  (res_out),
        .o_empty (res_empty),
        .o_count (res_count)
    );

    assign o_m_tvalid = !res_empty;
    assign o_m_tdata  = res_out.data;
    assign o_m_tlast  = res_out.last;
    assign o_m_tuser  = res_out.done;

endmodule
